[src/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Request and response types, command and status codes, controller states
// and parameter defaults used by the allocator top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

   localparam int INODE_SLOTS_DEF      = 64;
   localparam int BLOCK_SLOTS_DEF      = 1024;
   localparam int FIRST_DATA_BLOCK_DEF = 7;

   localparam int WORD_W = 32;

   localparam logic [1:0] CMD_ALLOC_INODE = 2'd0;
   localparam logic [1:0] CMD_FREE_INODE  = 2'd1;
   localparam logic [1:0] CMD_ALLOC_BLOCK = 2'd2;
   localparam logic [1:0] CMD_FREE_BLOCK  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  granted_index;
      logic [6:0]  inodes_free;
      logic [10:0] blocks_free;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

[src/bitmap_first_free_allocator.sv]
// ----------------------------------------------------------------------------
// Bitmap first-free allocator
// Inode and block bitmap pools with free counters, first-fit search over
// 32-bit bitmap words held in two synchronous RAMs.
//
// Requests arrive on req_valid/req_ready with a command and a slot index.
// Every request yields one response on rsp_valid/rsp_ready carrying the
// status, the granted index and both free counters after the command.
// An alloc reads one bitmap word per cycle from its start word until a
// word with a clear bit is found or the last word of the pool is read,
// writing the found word back in that cycle. At most 32 words are read for
// the default block pool. A free reads the word, then modifies and writes
// it; a rejected free goes straight to the response. req_ready stays low
// until the response is registered, so a new request is not taken while
// one is in flight. The bitmap RAM port, one word per cycle, sets the
// search time.
// After reset the controller sweeps both RAMs to load the initial maps,
// stepping through as many words as the larger pool has (32 by default);
// req_ready stays low during the sweep. A finished response waits in an
// output register; while the receiver stalls a new request is still
// accepted, and its response waits until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator #(
   parameter int INODE_SLOTS      = bffa_pkg::INODE_SLOTS_DEF,
   parameter int BLOCK_SLOTS      = bffa_pkg::BLOCK_SLOTS_DEF,
   parameter int FIRST_DATA_BLOCK = bffa_pkg::FIRST_DATA_BLOCK_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bffa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bffa_pkg::rsp_type      rsp_data
);

   localparam int WW         = bffa_pkg::WORD_W;
   localparam int IW         = (INODE_SLOTS + WW - 1) / WW;
   localparam int BW         = (BLOCK_SLOTS + WW - 1) / WW;
   localparam int IAW        = (IW > 1) ? $clog2(IW) : 1;
   localparam int BAW        = (BW > 1) ? $clog2(BW) : 1;
   localparam int MAXW       = (IW > BW) ? IW : BW;
   localparam int PW         = (MAXW > 1) ? $clog2(MAXW) : 1;
   localparam int ICW        = $clog2(INODE_SLOTS + 1);
   localparam int BCW        = $clog2(BLOCK_SLOTS + 1);
   localparam int DATA_POOL  = BLOCK_SLOTS - FIRST_DATA_BLOCK;
   localparam int START_WORD = FIRST_DATA_BLOCK / WW;
   localparam int XW         = PW + 6;

   bffa_pkg::state_type state_ff, state_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [4:0]          bitpos_ff, bitpos_in;
   logic [ICW-1:0]      icnt_ff, icnt_in;
   logic [BCW-1:0]      bcnt_ff, bcnt_in;
   logic [1:0]          status_ff, status_in;
   logic [9:0]          granted_ff, granted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bffa_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic            i_wr_en, i_rd_en, b_wr_en, b_rd_en;
   logic [IAW-1:0]  i_wr_addr, i_rd_addr;
   logic [BAW-1:0]  b_wr_addr, b_rd_addr;
   logic [WW-1:0]   i_wr_data, b_wr_data, i_rd_data, b_rd_data;

   logic            is_block;
   logic [WW-1:0]   cur_word;
   logic            word_has_free;
   logic [4:0]      free_pos;
   logic [PW-1:0]   ptr_next;
   logic [PW-1:0]   scan_last;
   logic [PW-1:0]   free_word;
   logic            inode_in_range, block_in_range;
   logic            out_slot_free;
   logic [31:0]     grant_wide, icnt_wide, bcnt_wide;

   function automatic logic [4:0] lowest_set(input logic [WW-1:0] v);
      logic [4:0] pos;
      pos = '0;
      for (int b = WW - 1; b >= 0; b--) begin
         if (v[b]) begin
            pos = 5'(b);
         end
      end
      return pos;
   endfunction

   function automatic logic [WW-1:0] inode_init_word(input logic [PW-1:0] w);
      logic [WW-1:0] r;
      logic [XW-1:0] ix;
      for (int b = 0; b < WW; b++) begin
         ix   = {1'b0, w, 5'(b)};
         r[b] = (ix >= XW'(INODE_SLOTS));
      end
      return r;
   endfunction

   function automatic logic [WW-1:0] block_init_word(input logic [PW-1:0] w);
      logic [WW-1:0] r;
      logic [XW-1:0] ix;
      for (int b = 0; b < WW; b++) begin
         ix   = {1'b0, w, 5'(b)};
         r[b] = (ix < XW'(FIRST_DATA_BLOCK)) || (ix >= XW'(BLOCK_SLOTS));
      end
      return r;
   endfunction

   bffa_ram #(.WIDTH(WW), .DEPTH(IW)) u_inode_ram (
      .clock   (clock),
      .wr_en   (i_wr_en),
      .wr_addr (i_wr_addr),
      .wr_data (i_wr_data),
      .rd_en   (i_rd_en),
      .rd_addr (i_rd_addr),
      .rd_data (i_rd_data)
   );

   bffa_ram #(.WIDTH(WW), .DEPTH(BW)) u_block_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign is_block       = (cmd_ff == bffa_pkg::CMD_ALLOC_BLOCK) ||
                           (cmd_ff == bffa_pkg::CMD_FREE_BLOCK);
   assign cur_word       = is_block ? b_rd_data : i_rd_data;
   assign word_has_free  = ~&cur_word;
   assign free_pos       = lowest_set(~cur_word);
   assign ptr_next       = PW'(ptr_ff + 1'b1);
   assign scan_last      = is_block ? PW'(BW - 1) : PW'(IW - 1);
   assign free_word      = PW'(req_data.slot_index[9:5]);
   assign inode_in_range = ({1'b0, req_data.slot_index} < 11'(INODE_SLOTS));
   assign block_in_range = ({7'd0, req_data.slot_index} >= 17'(FIRST_DATA_BLOCK)) &&
                           ({7'd0, req_data.slot_index} < 17'(BLOCK_SLOTS));
   assign out_slot_free  = !rsp_valid_ff || rsp_ready;
   assign grant_wide     = 32'({ptr_ff, free_pos});
   assign icnt_wide      = 32'(icnt_ff);
   assign bcnt_wide      = 32'(bcnt_ff);

   assign req_ready = (state_ff == bffa_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bffa_pkg::S_CLEAR: begin
            if (ptr_ff == PW'(MAXW - 1)) begin
               state_in = bffa_pkg::S_IDLE;
            end
         end
         bffa_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  bffa_pkg::CMD_ALLOC_INODE: state_in = bffa_pkg::S_SCAN;
                  bffa_pkg::CMD_ALLOC_BLOCK: state_in = bffa_pkg::S_SCAN;
                  bffa_pkg::CMD_FREE_INODE:
                     state_in = inode_in_range ? bffa_pkg::S_FREE : bffa_pkg::S_RESP;
                  default:
                     state_in = block_in_range ? bffa_pkg::S_FREE : bffa_pkg::S_RESP;
               endcase
            end
         end
         bffa_pkg::S_SCAN: begin
            if (word_has_free || (ptr_ff == scan_last)) begin
               state_in = bffa_pkg::S_RESP;
            end
         end
         bffa_pkg::S_FREE: begin
            state_in = bffa_pkg::S_RESP;
         end
         bffa_pkg::S_RESP: begin
            if (out_slot_free) begin
               state_in = bffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bffa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ptr_in       = ptr_ff;
      cmd_in       = cmd_ff;
      bitpos_in    = bitpos_ff;
      icnt_in      = icnt_ff;
      bcnt_in      = bcnt_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      i_wr_en      = 1'b0;
      i_wr_addr    = ptr_ff[IAW-1:0];
      i_wr_data    = '0;
      i_rd_en      = 1'b0;
      i_rd_addr    = ptr_ff[IAW-1:0];
      b_wr_en      = 1'b0;
      b_wr_addr    = ptr_ff[BAW-1:0];
      b_wr_data    = '0;
      b_rd_en      = 1'b0;
      b_rd_addr    = ptr_ff[BAW-1:0];

      unique case (state_ff)
         bffa_pkg::S_CLEAR: begin
            ptr_in    = ptr_next;
            i_wr_en   = ({1'b0, ptr_ff} < (PW + 1)'(IW));
            i_wr_data = inode_init_word(ptr_ff);
            b_wr_en   = ({1'b0, ptr_ff} < (PW + 1)'(BW));
            b_wr_data = block_init_word(ptr_ff);
         end
         bffa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               bitpos_in  = req_data.slot_index[4:0];
               status_in  = bffa_pkg::ST_OK;
               granted_in = '0;
               unique case (req_data.cmd)
                  bffa_pkg::CMD_ALLOC_INODE: begin
                     ptr_in    = '0;
                     i_rd_en   = 1'b1;
                     i_rd_addr = '0;
                  end
                  bffa_pkg::CMD_ALLOC_BLOCK: begin
                     ptr_in    = PW'(START_WORD);
                     b_rd_en   = 1'b1;
                     b_rd_addr = BAW'(START_WORD);
                  end
                  bffa_pkg::CMD_FREE_INODE: begin
                     ptr_in    = free_word;
                     i_rd_en   = inode_in_range;
                     i_rd_addr = free_word[IAW-1:0];
                     if (!inode_in_range) begin
                        status_in = bffa_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     ptr_in    = free_word;
                     b_rd_en   = block_in_range;
                     b_rd_addr = free_word[BAW-1:0];
                     if (!block_in_range) begin
                        status_in = bffa_pkg::ST_RANGE;
                     end
                  end
               endcase
            end
         end
         bffa_pkg::S_SCAN: begin
            if (word_has_free) begin
               granted_in = grant_wide[9:0];
               if (is_block) begin
                  b_wr_en   = 1'b1;
                  b_wr_data = cur_word | (WW'(1) << free_pos);
                  if (bcnt_ff != '0) begin
                     bcnt_in = BCW'(bcnt_ff - 1'b1);
                  end
               end else begin
                  i_wr_en   = 1'b1;
                  i_wr_data = cur_word | (WW'(1) << free_pos);
                  if (icnt_ff != '0) begin
                     icnt_in = ICW'(icnt_ff - 1'b1);
                  end
               end
            end else if (ptr_ff == scan_last) begin
               status_in = bffa_pkg::ST_FULL;
            end else begin
               ptr_in    = ptr_next;
               i_rd_en   = !is_block;
               i_rd_addr = ptr_next[IAW-1:0];
               b_rd_en   = is_block;
               b_rd_addr = ptr_next[BAW-1:0];
            end
         end
         bffa_pkg::S_FREE: begin
            if (is_block) begin
               b_wr_en   = 1'b1;
               b_wr_data = cur_word & ~(WW'(1) << bitpos_ff);
               if (bcnt_ff < BCW'(DATA_POOL)) begin
                  bcnt_in = BCW'(bcnt_ff + 1'b1);
               end
            end else begin
               i_wr_en   = 1'b1;
               i_wr_data = cur_word & ~(WW'(1) << bitpos_ff);
               if (icnt_ff < ICW'(INODE_SLOTS)) begin
                  icnt_in = ICW'(icnt_ff + 1'b1);
               end
            end
         end
         bffa_pkg::S_RESP: begin
            if (out_slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.granted_index = granted_ff;
               rsp_data_in.inodes_free   = icnt_wide[6:0];
               rsp_data_in.blocks_free   = bcnt_wide[10:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bffa_pkg::S_CLEAR;
         ptr_ff       <= '0;
         icnt_ff      <= ICW'(INODE_SLOTS);
         bcnt_ff      <= BCW'(DATA_POOL);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         icnt_ff      <= icnt_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      bitpos_ff   <= bitpos_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[src/bffa_ram.sv]
// ----------------------------------------------------------------------------
// Bitmap first-free allocator RAM
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
